@@ rtl/core/saq_pkg.sv @@
`default_nettype none

package saq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TIME_W      = 32;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W      = $clog2((QUEUE_DEPTH > 1) ? QUEUE_DEPTH : 2);
  localparam int COUNT_OUT_W = 5;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [TIME_W-1:0] time_t;

  typedef enum logic [1:0] {
    OP_SCHED = 2'd0,
    OP_CHECK = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_UNSET = 3'd1,
    ST_RANGE = 3'd2,
    ST_FAULT = 3'd3,
    ST_PAST  = 3'd4,
    ST_FULL  = 3'd5,
    ST_BUSY  = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CMP,
    S_INS_PUT,
    S_RM_SH,
    S_FIN
  } seq_state_t;

  typedef enum logic {
    REG_MIN_TIME = 1'b0,
    REG_MAX_TIME = 1'b1
  } reg_idx_t;

  typedef struct packed {
    time_t min_time;
    time_t max_time;
  } cfg_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    time_t wdata;
    addr_t raddr;
  } mem_req_t;

endpackage

`default_nettype wire

@@ rtl/core/saq_if.sv @@
`default_nettype none

interface saq_in_if import saq_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  time_t       alarm_time;
  time_t       rtc_time;
  logic        clock_valid;
  logic        clock_fault;
  logic        payload_busy;

  modport source (
    output valid, opcode, alarm_time, rtc_time, clock_valid, clock_fault, payload_busy,
    input  ready
  );
  modport sink (
    input  valid, opcode, alarm_time, rtc_time, clock_valid, clock_fault, payload_busy,
    output ready
  );
endinterface

interface saq_out_if import saq_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [2:0]             status;
  logic                   fire;
  logic [COUNT_OUT_W-1:0] pending_count;
  time_t                  head_time;

  modport source (
    output valid, status, fire, pending_count, head_time,
    input  ready
  );
  modport sink (
    input  valid, status, fire, pending_count, head_time,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/core/saq_cfg.sv @@
`default_nettype none

module saq_cfg import saq_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [APB_AW-1:0] cfg_paddr,
  input  wire logic [APB_DW-1:0] cfg_pwdata,
  output      logic [APB_DW-1:0] cfg_prdata,
  output      logic              cfg_pready,
  output      cfg_t              cfg
);

  time_t    min_r, max_r;
  logic     wr_en;
  reg_idx_t sel;

  assign sel        = reg_idx_t'(cfg_paddr[2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= '0;
      max_r <= '1;
    end else if (wr_en) begin
      case (sel)
        REG_MIN_TIME: min_r <= cfg_pwdata;
        REG_MAX_TIME: max_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_MIN_TIME: cfg_prdata = min_r;
      REG_MAX_TIME: cfg_prdata = max_r;
      default:      cfg_prdata = '0;
    endcase
  end

  assign cfg.min_time = min_r;
  assign cfg.max_time = max_r;

endmodule

`default_nettype wire

@@ rtl/core/saq_store.sv @@
`default_nettype none

module saq_store import saq_pkg::*; (
  input  wire logic     clk,
  input  wire mem_req_t req,
  output      time_t    rdata,
  output      time_t    head
);

  time_t mem [QUEUE_DEPTH];
  time_t rdata_r;
  time_t head_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  // shadow copy of entry zero
  always_ff @(posedge clk) begin
    if (req.we && (req.waddr == '0)) begin
      head_r <= req.wdata;
    end
  end

  assign rdata = rdata_r;
  assign head  = head_r;

endmodule

`default_nettype wire

@@ rtl/core/saq_ctrl.sv @@
`default_nettype none

module saq_ctrl import saq_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire cfg_t     cfg,
  saq_in_if.sink        in_bus,
  saq_out_if.source     out_bus,
  output      mem_req_t req,
  input  wire time_t    rdata,
  input  wire time_t    head
);

  seq_state_t state_r, state_nxt;
  cnt_t       count_r, count_nxt;
  cnt_t       idx_r, idx_nxt;
  time_t      t_r, t_nxt;
  status_t    st_r, st_nxt;
  logic       fire_r, fire_nxt;

  logic                   ov_r, ov_nxt;
  status_t                ost_r, ost_nxt;
  logic                   ofire_r, ofire_nxt;
  logic [COUNT_OUT_W-1:0] ocnt_r, ocnt_nxt;
  time_t                  ohead_r, ohead_nxt;

  cnt_t count_m1, idx_m1, idx_m2, idx_p1, idx_p2;
  logic accept, take;
  logic t_le_rd;

  assign count_m1 = count_r - cnt_t'(1);
  assign idx_m1   = idx_r - cnt_t'(1);
  assign idx_m2   = idx_r - cnt_t'(2);
  assign idx_p1   = idx_r + cnt_t'(1);
  assign idx_p2   = idx_r + cnt_t'(2);

  assign in_bus.ready = (state_r == S_IDLE);
  assign accept       = in_bus.valid && in_bus.ready;
  assign take         = ov_r && out_bus.ready;

  // comparator for the insertion walk
  assign t_le_rd = (t_r <= rdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    t_r     <= t_nxt;
    st_r    <= st_nxt;
    fire_r  <= fire_nxt;
    ost_r   <= ost_nxt;
    ofire_r <= ofire_nxt;
    ocnt_r  <= ocnt_nxt;
    ohead_r <= ohead_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    t_nxt     = t_r;
    st_nxt    = st_r;
    fire_nxt  = fire_r;
    ov_nxt    = take ? 1'b0 : ov_r;
    ost_nxt   = ost_r;
    ofire_nxt = ofire_r;
    ocnt_nxt  = ocnt_r;
    ohead_nxt = ohead_r;
    req       = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          st_nxt    = ST_OK;
          fire_nxt  = 1'b0;
          state_nxt = S_FIN;
          t_nxt     = in_bus.alarm_time;
          if (in_bus.opcode == OP_SCHED) begin
            if (!in_bus.clock_valid) begin
              st_nxt = ST_UNSET;
            end else if ((in_bus.alarm_time < cfg.min_time) ||
                         (in_bus.alarm_time > cfg.max_time)) begin
              st_nxt = ST_RANGE;
            end else if (in_bus.clock_fault) begin
              st_nxt = ST_FAULT;
            end else if (in_bus.alarm_time < in_bus.rtc_time) begin
              st_nxt = ST_PAST;
            end else if (count_r >= cnt_t'(QUEUE_DEPTH)) begin
              st_nxt = ST_FULL;
            end else begin
              idx_nxt   = count_r;
              count_nxt = count_r + cnt_t'(1);
              if (count_r == '0) begin
                state_nxt = S_INS_PUT;
              end else begin
                req.raddr = count_m1[ADDR_W-1:0];
                state_nxt = S_INS_CMP;
              end
            end
          end else if (in_bus.opcode == OP_CHECK) begin
            if (!in_bus.clock_valid) begin
              st_nxt = ST_UNSET;
            end else if (in_bus.clock_fault) begin
              st_nxt    = ST_FAULT;
              count_nxt = '0;
            end else if ((in_bus.rtc_time < cfg.min_time) ||
                         (in_bus.rtc_time > cfg.max_time)) begin
              st_nxt    = ST_RANGE;
              count_nxt = '0;
            end else if ((count_r != '0) && (in_bus.rtc_time >= head)) begin
              count_nxt = count_m1;
              if (in_bus.payload_busy) begin
                st_nxt = ST_BUSY;
              end else begin
                fire_nxt = 1'b1;
              end
              if (count_m1 != '0) begin
                idx_nxt   = '0;
                req.raddr = addr_t'(1);
                state_nxt = S_RM_SH;
              end
            end
          end else if (in_bus.opcode == OP_CLEAR) begin
            count_nxt = '0;
          end
        end
      end

      S_INS_CMP: begin
        req.we    = 1'b1;
        req.waddr = idx_r[ADDR_W-1:0];
        if (t_le_rd) begin
          req.wdata = rdata;
          idx_nxt   = idx_m1;
          if (idx_r == cnt_t'(1)) begin
            state_nxt = S_INS_PUT;
          end else begin
            req.raddr = idx_m2[ADDR_W-1:0];
          end
        end else begin
          req.wdata = t_r;
          state_nxt = S_FIN;
        end
      end

      S_INS_PUT: begin
        req.we    = 1'b1;
        req.waddr = idx_r[ADDR_W-1:0];
        req.wdata = t_r;
        state_nxt = S_FIN;
      end

      S_RM_SH: begin
        req.we    = 1'b1;
        req.waddr = idx_r[ADDR_W-1:0];
        req.wdata = rdata;
        idx_nxt   = idx_p1;
        if (idx_p1 < count_r) begin
          req.raddr = idx_p2[ADDR_W-1:0];
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        if (!ov_r || out_bus.ready) begin
          ov_nxt    = 1'b1;
          ost_nxt   = st_r;
          ofire_nxt = fire_r;
          ocnt_nxt  = COUNT_OUT_W'(count_r);
          ohead_nxt = (count_r != '0) ? head : '0;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_bus.valid         = ov_r;
  assign out_bus.status        = ost_r;
  assign out_bus.fire          = ofire_r;
  assign out_bus.pending_count = ocnt_r;
  assign out_bus.head_time     = ohead_r;

endmodule

`default_nettype wire

@@ rtl/core/sorted_alarm_time_queue_unit.sv @@
`default_nettype none

// Channel  Dir  Handshake          Beat contents
// in_bus   in   valid/ready        opcode, alarm_time, rtc_time, clock_valid,
//                                  clock_fault, payload_busy
// out_bus  out  valid/ready        status, fire, pending_count, head_time
// cfg_*    in   APB write/read     min_valid_time @ 0x0, max_valid_time @ 0x4
//
// One beat in, one beat out. Rejects, clear and check without removal go straight to the result state.
// Sorted insert walks the store from the tail toward the head, moving larger entries up.
// Head removal shifts the remaining entries down by one place.
// rst_n is synchronous; it empties the queue and restores the window registers.
// in_bus.ready is high only between items; a stalled out_bus holds the result register.

module sorted_alarm_time_queue_unit import saq_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  saq_in_if.sink                 in_bus,
  saq_out_if.source              out_bus,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [APB_AW-1:0] cfg_paddr,
  input  wire logic [APB_DW-1:0] cfg_pwdata,
  output      logic [APB_DW-1:0] cfg_prdata,
  output      logic              cfg_pready
);

  cfg_t     cfg;
  mem_req_t req;
  time_t    rdata;
  time_t    head;

  saq_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  saq_store u_store (
    .clk   (clk),
    .req   (req),
    .rdata (rdata),
    .head  (head)
  );

  saq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .req     (req),
    .rdata   (rdata),
    .head    (head)
  );

endmodule

`default_nettype wire

@@ bench/tb_sorted_alarm_time_queue_unit.sv @@
module tb_sorted_alarm_time_queue_unit;
  import saq_pkg::*;

  localparam int          CYCLE_LIMIT = 1000000;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam int          NUM_PHASES  = 7;

  typedef struct packed {
    logic [1:0] opcode;
    time_t      alarm_time;
    time_t      rtc_time;
    logic       clock_valid;
    logic       clock_fault;
    logic       payload_busy;
  } alarm_cmd_t;

  typedef struct packed {
    status_t                status;
    logic                   fire;
    logic [COUNT_OUT_W-1:0] pending;
    time_t                  head;
  } alarm_reply_t;

  typedef struct {
    bit           set_win;
    time_t        lo;
    time_t        hi;
    int           reps;
    alarm_cmd_t   cmd;
    bit           typed;
    alarm_reply_t reply;
  } vector_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [APB_AW-1:0] cfg_paddr   = '0;
  logic [APB_DW-1:0] cfg_pwdata  = '0;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  logic sink_ready = 1'b0;
  int   sink_hold  = 0;
  bit   sink_calm  = 1'b0;
  bit   src_calm   = 1'b0;

  int mismatches = 0;
  int cycle_cnt  = 0;

  // queue model state
  time_t        queued_alarms[$];
  time_t        win_lo = '0;
  time_t        win_hi = '1;
  time_t        now_t  = '0;
  alarm_reply_t awaited_replies[$];
  vector_row_t  vectors[$];

  saq_in_if  in_if ();
  saq_out_if out_if ();

  assign out_if.ready = sink_ready;

  sorted_alarm_time_queue_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_bus      (in_if.sink),
    .out_bus     (out_if.source),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    int roll;
    roll = $urandom_range(0, 99);
    if (sink_hold > 0) begin
      sink_hold--;
    end else if (!sink_calm && roll < 25) begin
      sink_hold = (roll < 3) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    end
    sink_ready <= (sink_hold == 0);
  end

  always @(posedge clk) begin
    alarm_reply_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (awaited_replies.size() == 0) begin
        $error("result beat with nothing pending: status %0d count %0d head %0h",
               out_if.status, out_if.pending_count, out_if.head_time);
        mismatches++;
      end else begin
        want = awaited_replies.pop_front();
        if (out_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_if.status);
          mismatches++;
        end
        if (out_if.fire !== want.fire) begin
          $error("fire: expected %0d, got %0d", want.fire, out_if.fire);
          mismatches++;
        end
        if (out_if.pending_count !== want.pending) begin
          $error("pending_count: expected %0d, got %0d", want.pending, out_if.pending_count);
          mismatches++;
        end
        if (out_if.head_time !== want.head) begin
          $error("head_time: expected %0h, got %0h", want.head, out_if.head_time);
          mismatches++;
        end
      end
    end
  end

  function automatic bit in_window(time_t t);
    return t >= win_lo && t <= win_hi;
  endfunction

  // applies one beat to the queue model and returns the reply it yields
  function automatic alarm_reply_t advance_alarm_queue(alarm_cmd_t c);
    alarm_reply_t r;
    int           pos;
    r.status = ST_OK;
    r.fire   = 1'b0;
    case (c.opcode)
      OP_SCHED: begin
        if (!c.clock_valid) r.status = ST_UNSET;
        else if (!in_window(c.alarm_time)) r.status = ST_RANGE;
        else if (c.clock_fault) r.status = ST_FAULT;
        else if (c.alarm_time < c.rtc_time) r.status = ST_PAST;
        else if (queued_alarms.size() >= QUEUE_DEPTH) r.status = ST_FULL;
        else begin
          pos = 0;
          while (pos < queued_alarms.size() && queued_alarms[pos] < c.alarm_time) pos++;
          queued_alarms.insert(pos, c.alarm_time);
        end
      end
      OP_CHECK: begin
        if (!c.clock_valid) begin
          r.status = ST_UNSET;
        end else if (c.clock_fault) begin
          queued_alarms.delete();
          r.status = ST_FAULT;
        end else if (!in_window(c.rtc_time)) begin
          queued_alarms.delete();
          r.status = ST_RANGE;
        end else if (queued_alarms.size() > 0 && c.rtc_time >= queued_alarms[0]) begin
          void'(queued_alarms.pop_front());
          if (c.payload_busy) r.status = ST_BUSY;
          else r.fire = 1'b1;
        end
      end
      OP_CLEAR: queued_alarms.delete();
      default: ;
    endcase
    r.pending = COUNT_OUT_W'(queued_alarms.size());
    r.head    = (queued_alarms.size() > 0) ? queued_alarms[0] : '0;
    return r;
  endfunction

  function automatic time_t pick_in(time_t lo, time_t hi);
    longint unsigned span;
    if (lo > hi) return $urandom;
    span = 64'(hi) - 64'(lo) + 64'd1;
    if (span > 64'hFFFF_FFFF) return $urandom;
    return lo + time_t'($urandom % span);
  endfunction

  function automatic time_t clip_hi(longint unsigned v);
    return (v > 64'(win_hi)) ? win_hi : time_t'(v);
  endfunction

  function automatic int pick_gap();
    int roll;
    if (src_calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // mostly well-formed traffic around a slowly advancing clock
  function automatic alarm_cmd_t random_cmd();
    alarm_cmd_t c;
    int         sel;
    c.alarm_time   = $urandom;
    c.rtc_time     = now_t;
    c.clock_valid  = ($urandom_range(0, 49) != 0);
    c.clock_fault  = ($urandom_range(0, 39) == 0);
    c.payload_busy = ($urandom_range(0, 4) == 0);
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      c.opcode = OP_SCHED;
      if ($urandom_range(0, 9) != 0) c.alarm_time = clip_hi(64'(now_t) + $urandom_range(0, 60));
      if ($urandom_range(0, 29) == 0) c.rtc_time = $urandom;
    end else if (sel < 93) begin
      c.opcode = OP_CHECK;
      now_t = clip_hi(64'(now_t) + $urandom_range(0, 25));
      if (now_t >= win_hi && $urandom_range(0, 3) == 0) now_t = pick_in(win_lo, win_hi);
      c.rtc_time = ($urandom_range(0, 24) == 0) ? time_t'($urandom) : now_t;
    end else if (sel < 97) begin
      c.opcode   = OP_CLEAR;
      c.rtc_time = $urandom;
    end else begin
      c.opcode   = OP_UNUSED;
      c.rtc_time = $urandom;
    end
    return c;
  endfunction

  task automatic send_cmd(input alarm_cmd_t c, input bit typed, input alarm_reply_t typed_reply);
    alarm_reply_t r;
    int           gap;
    in_if.valid        <= 1'b1;
    in_if.opcode       <= c.opcode;
    in_if.alarm_time   <= c.alarm_time;
    in_if.rtc_time     <= c.rtc_time;
    in_if.clock_valid  <= c.clock_valid;
    in_if.clock_fault  <= c.clock_fault;
    in_if.payload_busy <= c.payload_busy;
    do @(posedge clk); while (!in_if.ready);
    r = advance_alarm_queue(c);
    awaited_replies.push_back(typed ? typed_reply : r);
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input time_t val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic read_reg(input reg_idx_t idx, input time_t want);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== want) begin
      $error("cfg_prdata: expected %0h, got %0h", want, cfg_prdata);
      mismatches++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_window(input time_t lo, input time_t hi);
    wait_idle();
    write_reg(REG_MIN_TIME, lo);
    write_reg(REG_MAX_TIME, hi);
    win_lo = lo;
    win_hi = hi;
    read_reg(REG_MIN_TIME, lo);
    read_reg(REG_MAX_TIME, hi);
  endtask

  function automatic void add_row(logic [1:0] op, time_t t, time_t now, bit cv, bit cf,
                                  bit busy, int reps, bit typed, status_t st, bit fire,
                                  int cnt, time_t head);
    vector_row_t v;
    v.set_win = 1'b0;
    v.lo      = '0;
    v.hi      = '0;
    v.reps    = reps;
    v.cmd     = '{opcode: op, alarm_time: t, rtc_time: now, clock_valid: cv,
                  clock_fault: cf, payload_busy: busy};
    v.typed   = typed;
    v.reply   = '{status: st, fire: fire, pending: COUNT_OUT_W'(cnt), head: head};
    vectors.push_back(v);
  endfunction

  function automatic void add_window(time_t lo, time_t hi);
    vector_row_t v;
    v.set_win = 1'b1;
    v.lo      = lo;
    v.hi      = hi;
    v.reps    = 0;
    v.cmd     = '0;
    v.typed   = 1'b0;
    v.reply   = '{status: ST_OK, fire: 1'b0, pending: '0, head: '0};
    vectors.push_back(v);
  endfunction

  initial begin
    time_t lo;
    time_t hi;
    int    n_items;
    in_if.valid        <= 1'b0;
    in_if.opcode       <= OP_CLEAR;
    in_if.alarm_time   <= '0;
    in_if.rtc_time     <= '0;
    in_if.clock_valid  <= 1'b0;
    in_if.clock_fault  <= 1'b0;
    in_if.payload_busy <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // full window after reset
    add_row(OP_CHECK, 0, 0, 1, 0, 0, 1, 1, ST_OK, 0, 0, 0);
    add_row(OP_SCHED, 0, 0, 0, 0, 0, 1, 1, ST_UNSET, 0, 0, 0);
    add_row(OP_SCHED, 10, 20, 1, 1, 0, 1, 1, ST_FAULT, 0, 0, 0);
    add_row(OP_SCHED, 5, 6, 1, 0, 0, 1, 1, ST_PAST, 0, 0, 0);
    add_row(OP_SCHED, 0, 0, 1, 0, 0, 1, 1, ST_OK, 0, 1, 0);
    add_row(OP_SCHED, '1, '1, 1, 0, 0, 1, 1, ST_OK, 0, 2, 0);
    add_row(OP_SCHED, 0, 0, 1, 0, 0, 1, 1, ST_OK, 0, 3, 0);
    add_row(OP_CHECK, 0, 0, 1, 0, 1, 1, 1, ST_BUSY, 0, 2, 0);
    add_row(OP_CHECK, 0, 0, 1, 0, 0, 1, 1, ST_OK, 1, 1, '1);
    add_row(OP_CHECK, 0, 32'hFFFF_FFFE, 1, 0, 0, 1, 1, ST_OK, 0, 1, '1);
    add_row(OP_SCHED, '1, 32'h8000_0000, 1, 0, 0, QUEUE_DEPTH - 1, 0, ST_OK, 0, 0, 0);
    add_row(OP_SCHED, '1, 0, 1, 0, 0, 1, 1, ST_FULL, 0, QUEUE_DEPTH, '1);
    add_row(OP_UNUSED, 32'h1234_5678, '1, 1, 1, 1, 1, 1, ST_OK, 0, QUEUE_DEPTH, '1);
    add_row(OP_CHECK, 0, '1, 0, 1, 0, 1, 1, ST_UNSET, 0, QUEUE_DEPTH, '1);
    add_row(OP_CHECK, 0, '1, 1, 0, 1, 1, 1, ST_BUSY, 0, QUEUE_DEPTH - 1, '1);
    add_row(OP_CLEAR, '1, '1, 0, 1, 1, 1, 1, ST_OK, 0, 0, 0);
    // narrow window
    add_window(1000, 2000);
    add_row(OP_SCHED, 999, 0, 1, 1, 0, 1, 1, ST_RANGE, 0, 0, 0);
    add_row(OP_SCHED, 2001, 0, 1, 0, 0, 1, 1, ST_RANGE, 0, 0, 0);
    add_row(OP_SCHED, 1000, 1000, 1, 0, 0, 1, 1, ST_OK, 0, 1, 1000);
    add_row(OP_SCHED, 2000, 1500, 1, 0, 0, 1, 1, ST_OK, 0, 2, 1000);
    add_row(OP_CHECK, 0, 999, 1, 0, 0, 1, 1, ST_RANGE, 0, 0, 0);
    add_row(OP_SCHED, 1500, 1000, 1, 0, 0, 1, 1, ST_OK, 0, 1, 1500);
    add_row(OP_CHECK, 0, 2001, 1, 1, 0, 1, 1, ST_FAULT, 0, 0, 0);
    // inverted window
    add_window(5, 4);
    add_row(OP_SCHED, 5, 0, 1, 0, 0, 1, 1, ST_RANGE, 0, 0, 0);
    add_row(OP_SCHED, 4, 0, 1, 0, 0, 1, 1, ST_RANGE, 0, 0, 0);
    add_row(OP_CHECK, 0, 4, 1, 0, 0, 1, 1, ST_RANGE, 0, 0, 0);

    foreach (vectors[i]) begin
      if (vectors[i].set_win) begin
        set_window(vectors[i].lo, vectors[i].hi);
      end else begin
        repeat (vectors[i].reps) send_cmd(vectors[i].cmd, vectors[i].typed, vectors[i].reply);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      n_items = 250;
      case (p)
        0: begin lo = '0; hi = '1; end
        1: begin lo = '0; hi = '0; n_items = 150; end
        2: begin lo = '1; hi = '1; n_items = 150; end
        3: begin
          lo = $urandom_range(0, 32'hFFFF_0000);
          hi = lo + $urandom_range(100, 5000);
        end
        4: begin lo = '1; hi = '0; n_items = 100; end
        5: begin lo = '0; hi = '1; end
        default: begin lo = $urandom_range(0, 1000); hi = '1; end
      endcase
      set_window(lo, hi);
      src_calm  = (p == 2 || p == 5);
      sink_calm = (p == 1 || p == 5);
      now_t     = pick_in(lo, hi);
      repeat (n_items) send_cmd(random_cmd(), 1'b0, '0);
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && awaited_replies.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
